/* hw/rtl/htsc_pkg.sv */
// Shared types, codes and helpers for the humidity / temperature converter.
package htsc_pkg;

  localparam int DEF_FRAC_BITS = 24;

  // Configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 3;
  localparam logic [CFG_AW-1:0] CFG_SUPPLY = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_RES    = 1'b1;

  // Supply selector codes; anything above 5 V acts as 5 V
  localparam logic [2:0] VSEL_2V5 = 3'd0;
  localparam logic [2:0] VSEL_3V0 = 3'd1;
  localparam logic [2:0] VSEL_3V5 = 3'd2;
  localparam logic [2:0] VSEL_4V0 = 3'd3;
  localparam logic [2:0] VSEL_5V0 = 3'd4;

  localparam logic RES_LOW  = 1'b0;
  localparam logic RES_HIGH = 1'b1;

  // Humidity clamp codes
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HIGH = 2'd1;
  localparam logic [1:0] CLAMP_LOW  = 2'd2;

  localparam logic [13:0] RH_MAX_CENTI = 14'd10000;
  localparam logic [13:0] RH_MIN_CENTI = 14'd10;

  typedef struct packed {
    logic [13:0] raw_temp;
    logic [11:0] raw_hum;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temp_c_centi;
    logic signed [15:0] temp_f_centi;
    logic [13:0]        rh_centi;
    logic [1:0]         rh_clamp;
  } out_word_t;

  // Stage enables handed to the split multiplier
  typedef struct packed {
    logic s4;
    logic s5;
  } mul_en_t;

  // Apply sign to a centi magnitude and saturate to 16 bits
  function automatic logic signed [15:0] sat_centi(input logic neg, input logic [16:0] m);
    logic [16:0] n;
    n = 17'd0 - m;
    if (neg) begin
      return (m > 17'd32768) ? 16'sh8000 : $signed(n[15:0]);
    end
    return (m > 17'd32767) ? 16'sh7fff : $signed(m[15:0]);
  endfunction

endpackage

/* hw/rtl/humidity_temp_sensor_converter.sv */
// Top level: raw sensor counts to centi-degrees and compensated centi-%RH.
// Throughput: one word per cycle through eight register stages while out_stall is low.
// Stalls: each stage advances when empty or when the next one advances.
// Reset (rst_n low, synchronous): pipeline valids clear; supply select 5 V,
//   high resolution.
module humidity_temp_sensor_converter #(
  parameter int FRAC_BITS = htsc_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  htsc_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output htsc_pkg::out_word_t           out_word,
  input  logic                          cfg_we,
  input  logic [htsc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [htsc_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int F    = FRAC_BITS;
  localparam int NST  = 8;
  localparam int VW   = F + 17;  // signed fixed-point value width
  localparam int AW   = F + 10;  // |Tc - 25| magnitude
  localparam int BW   = F + 3;   // compensation factor t1 + t2*h
  localparam int MW   = AW + BW - F;
  localparam int D2W  = F - 3;   // d2 coefficients, all below 0.125
  localparam int C2W  = F;       // c2 below 1
  localparam int T2W  = F - 9;   // t2 below 2^-9
  localparam int C3W  = F - 10;  // |c3| below 2^-10
  localparam int TCMW = F + 10;
  localparam int TFMW = F + 11;
  localparam int TCXW = F + 17;
  localparam int TFXW = F + 18;
  localparam int RHXW = F + 14;

  localparam longint ONE  = longint'(1) <<< F;
  localparam longint HALF = ONE >>> 1;
  localparam longint MID  = 25 * ONE;

  // Coefficients, rounded half away from zero
  localparam longint D1C_0 = -((394 * ONE + 5) / 10);
  localparam longint D1C_1 = -((396 * ONE + 5) / 10);
  localparam longint D1C_2 = -((397 * ONE + 5) / 10);
  localparam longint D1C_3 = -((398 * ONE + 5) / 10);
  localparam longint D1C_4 = -((401 * ONE + 5) / 10);
  localparam longint D1F_0 = -((389 * ONE + 5) / 10);
  localparam longint D1F_1 = -((393 * ONE + 5) / 10);
  localparam longint D1F_2 = -((395 * ONE + 5) / 10);
  localparam longint D1F_3 = -((396 * ONE + 5) / 10);
  localparam longint D1F_4 = -((402 * ONE + 5) / 10);
  localparam longint D2C_LO = (40 * ONE + 500) / 1000;
  localparam longint D2C_HI = (10 * ONE + 500) / 1000;
  localparam longint D2F_LO = (72 * ONE + 500) / 1000;
  localparam longint D2F_HI = (18 * ONE + 500) / 1000;
  localparam longint C1     = -(4 * ONE);
  localparam longint C2_LO  = (6480 * ONE + 5000) / 10000;
  localparam longint C2_HI  = (405 * ONE + 5000) / 10000;
  localparam longint C3M_LO = (72 * ONE + 50000) / 100000;
  localparam longint C3M_HI = (28 * ONE + 5000000) / 10000000;
  localparam longint T1     = (ONE + 50) / 100;
  localparam longint T2_LO  = (128 * ONE + 50000) / 100000;
  localparam longint T2_HI  = (8 * ONE + 50000) / 100000;
  localparam longint RH_HI  = 100 * ONE;
  localparam longint RH_LOQ = (ONE - 1) / 10;  // largest value below 0.1 %RH

  // Configuration registers
  logic [2:0] supply_sel_r;
  logic       res_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_sel_r <= htsc_pkg::VSEL_5V0;
      res_sel_r    <= htsc_pkg::RES_HIGH;
    end else if (cfg_we) begin
      case (cfg_addr)
        htsc_pkg::CFG_SUPPLY: supply_sel_r <= cfg_wdata;
        htsc_pkg::CFG_RES:    res_sel_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads
  logic [NST:1] vld_r;
  logic [NST:1] vld_nxt;
  logic [NST:1] en;

  assign en[NST] = ~vld_r[NST] | ~out_stall;
  for (genvar k = 1; k < NST; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  always_comb begin
    vld_nxt = vld_r;
    for (int k = 1; k <= NST; k++) begin
      if (en[k]) begin
        vld_nxt[k] = (k == 1) ? in_valid : vld_r[(k > 1) ? k - 1 : 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = ~en[1];
  assign out_valid = vld_r[NST];

  // Stage 1: pick coefficients, first products
  logic signed [VW-1:0] d1c_sel, d1a_sel, d1f_sel;
  logic [D2W-1:0]       d2c_sel, d2f_sel;
  logic [C2W-1:0]       c2_sel;
  logic [C3W-1:0]       c3m_sel;
  logic [T2W-1:0]       t2_sel;

  always_comb begin
    case (supply_sel_r)
      htsc_pkg::VSEL_2V5: begin
        d1c_sel = VW'(D1C_0);
        d1a_sel = VW'(D1C_0 - MID);
        d1f_sel = VW'(D1F_0);
      end
      htsc_pkg::VSEL_3V0: begin
        d1c_sel = VW'(D1C_1);
        d1a_sel = VW'(D1C_1 - MID);
        d1f_sel = VW'(D1F_1);
      end
      htsc_pkg::VSEL_3V5: begin
        d1c_sel = VW'(D1C_2);
        d1a_sel = VW'(D1C_2 - MID);
        d1f_sel = VW'(D1F_2);
      end
      htsc_pkg::VSEL_4V0: begin
        d1c_sel = VW'(D1C_3);
        d1a_sel = VW'(D1C_3 - MID);
        d1f_sel = VW'(D1F_3);
      end
      default: begin
        // 5 V and the unused codes above it
        d1c_sel = VW'(D1C_4);
        d1a_sel = VW'(D1C_4 - MID);
        d1f_sel = VW'(D1F_4);
      end
    endcase
    if (res_sel_r == htsc_pkg::RES_LOW) begin
      d2c_sel = D2W'(D2C_LO);
      d2f_sel = D2W'(D2F_LO);
      c2_sel  = C2W'(C2_LO);
      c3m_sel = C3W'(C3M_LO);
      t2_sel  = T2W'(T2_LO);
    end else begin
      d2c_sel = D2W'(D2C_HI);
      d2f_sel = D2W'(D2F_HI);
      c2_sel  = C2W'(C2_HI);
      c3m_sel = C3W'(C3M_HI);
      t2_sel  = T2W'(T2_HI);
    end
  end

  logic [14+D2W-1:0]    s1_ptc_r, s1_ptf_r;
  logic [12+C2W-1:0]    s1_pc2_r;
  logic [23:0]          s1_hh_r;
  logic [12+T2W-1:0]    s1_pt2_r;
  logic signed [VW-1:0] s1_d1c_r, s1_d1a_r, s1_d1f_r;
  logic [C3W-1:0]       s1_c3m_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ptc_r <= (14+D2W)'(in_word.raw_temp) * (14+D2W)'(d2c_sel);
      s1_ptf_r <= (14+D2W)'(in_word.raw_temp) * (14+D2W)'(d2f_sel);
      s1_pc2_r <= (12+C2W)'(in_word.raw_hum) * (12+C2W)'(c2_sel);
      s1_hh_r  <= 24'(in_word.raw_hum) * 24'(in_word.raw_hum);
      s1_pt2_r <= (12+T2W)'(in_word.raw_hum) * (12+T2W)'(t2_sel);
      s1_d1c_r <= d1c_sel;
      s1_d1a_r <= d1a_sel;
      s1_d1f_r <= d1f_sel;
      s1_c3m_r <= c3m_sel;
    end
  end

  // Stage 2: temperatures, Tc - 25, compensation factor, c3*h^2
  logic signed [VW-1:0] s2_tc_r, s2_a_r, s2_tf_r, s2_lin0_r;
  logic [BW-1:0]        s2_fac_r;
  logic [24+C3W-1:0]    s2_pc3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_tc_r   <= s1_d1c_r + $signed(VW'(s1_ptc_r));
      s2_a_r    <= s1_d1a_r + $signed(VW'(s1_ptc_r));
      s2_tf_r   <= s1_d1f_r + $signed(VW'(s1_ptf_r));
      s2_lin0_r <= $signed(VW'(C1)) + $signed(VW'(s1_pc2_r));
      s2_fac_r  <= BW'(T1) + BW'(s1_pt2_r);
      s2_pc3_r  <= (24+C3W)'(s1_hh_r) * (24+C3W)'(s1_c3m_r);
    end
  end

  // Stage 3: magnitudes and signs, finish the linear humidity
  logic signed [VW-1:0] s2_tc_neg, s2_tf_neg, s2_a_neg;
  logic [TCMW-1:0]      s3_tcm_r;
  logic [TFMW-1:0]      s3_tfm_r;
  logic [AW-1:0]        s3_am_r;
  logic                 s3_tcn_r, s3_tfn_r, s3_an_r;
  logic [BW-1:0]        s3_fac_r;
  logic signed [VW-1:0] s3_lin1_r;

  assign s2_tc_neg = -s2_tc_r;
  assign s2_tf_neg = -s2_tf_r;
  assign s2_a_neg  = -s2_a_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_tcn_r  <= s2_tc_r[VW-1];
      s3_tfn_r  <= s2_tf_r[VW-1];
      s3_an_r   <= s2_a_r[VW-1];
      s3_tcm_r  <= s2_tc_r[VW-1] ? TCMW'(s2_tc_neg) : TCMW'(s2_tc_r);
      s3_tfm_r  <= s2_tf_r[VW-1] ? TFMW'(s2_tf_neg) : TFMW'(s2_tf_r);
      s3_am_r   <= s2_a_r[VW-1] ? AW'(s2_a_neg) : AW'(s2_a_r);
      s3_fac_r  <= s2_fac_r;
      s3_lin1_r <= s2_lin0_r - $signed(VW'(s2_pc3_r));
    end
  end

  // Stages 4 and 5: rounded |Tc - 25| * factor
  htsc_pkg::mul_en_t mul_en;
  logic [MW-1:0]     comp_mag;

  assign mul_en.s4 = en[4];
  assign mul_en.s5 = en[5];

  htsc_rnd_mul #(
    .FRAC_BITS (F),
    .A_W       (AW),
    .B_W       (BW)
  ) u_comp_mul (
    .clk   (clk),
    .en    (mul_en),
    .a_mag (s3_am_r),
    .b_mag (s3_fac_r),
    .prod  (comp_mag)
  );

  // Temperatures to centi alongside: scale by 100 and add the rounding half
  logic [TCXW-1:0]      s4_tcx_r;
  logic [TFXW-1:0]      s4_tfx_r;
  logic                 s4_tcn_r, s4_tfn_r, s4_an_r;
  logic signed [VW-1:0] s4_lin1_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_tcx_r  <= TCXW'(s3_tcm_r) * TCXW'(100) + TCXW'(HALF);
      s4_tfx_r  <= TFXW'(s3_tfm_r) * TFXW'(100) + TFXW'(HALF);
      s4_tcn_r  <= s3_tcn_r;
      s4_tfn_r  <= s3_tfn_r;
      s4_an_r   <= s3_an_r;
      s4_lin1_r <= s3_lin1_r;
    end
  end

  logic signed [15:0]   s5_tc_r, s5_tf_r;
  logic                 s5_an_r;
  logic signed [VW-1:0] s5_lin1_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_tc_r   <= htsc_pkg::sat_centi(s4_tcn_r, s4_tcx_r[F+16:F]);
      s5_tf_r   <= htsc_pkg::sat_centi(s4_tfn_r, s4_tfx_r[F+16:F]);
      s5_an_r   <= s4_an_r;
      s5_lin1_r <= s4_lin1_r;
    end
  end

  // Stage 6: apply compensation
  logic signed [VW-1:0] comp;
  logic signed [VW-1:0] s6_lin_r;
  logic signed [15:0]   s6_tc_r, s6_tf_r;

  assign comp = s5_an_r ? -$signed(VW'(comp_mag)) : $signed(VW'(comp_mag));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_lin_r <= s5_lin1_r + comp;
      s6_tc_r  <= s5_tc_r;
      s6_tf_r  <= s5_tf_r;
    end
  end

  // Stage 7: clamp decisions and unclamped centi value in parallel
  logic                 s7_hi_r, s7_lo_r;
  logic [RHXW-1:0]      s7_rhx_r;
  logic signed [15:0]   s7_tc_r, s7_tf_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_hi_r  <= s6_lin_r > $signed(VW'(RH_HI));
      s7_lo_r  <= s6_lin_r <= $signed(VW'(RH_LOQ));
      // only meaningful when neither clamp fires, so the value fits F+7 bits
      s7_rhx_r <= RHXW'(s6_lin_r[F+6:0]) * RHXW'(100) + RHXW'(HALF);
      s7_tc_r  <= s6_tc_r;
      s7_tf_r  <= s6_tf_r;
    end
  end

  // Stage 8: output register
  htsc_pkg::out_word_t out_word_nxt;
  htsc_pkg::out_word_t out_word_r;

  always_comb begin
    out_word_nxt.temp_c_centi = s7_tc_r;
    out_word_nxt.temp_f_centi = s7_tf_r;
    if (s7_hi_r) begin
      out_word_nxt.rh_centi = htsc_pkg::RH_MAX_CENTI;
      out_word_nxt.rh_clamp = htsc_pkg::CLAMP_HIGH;
    end else if (s7_lo_r) begin
      out_word_nxt.rh_centi = htsc_pkg::RH_MIN_CENTI;
      out_word_nxt.rh_clamp = htsc_pkg::CLAMP_LOW;
    end else begin
      out_word_nxt.rh_centi = s7_rhx_r[F+13:F];
      out_word_nxt.rh_clamp = htsc_pkg::CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_word = out_word_r;

`ifndef SYNTHESIS
  a_clamp_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.rh_clamp == htsc_pkg::CLAMP_NONE ||
                   out_word.rh_clamp == htsc_pkg::CLAMP_HIGH ||
                   out_word.rh_clamp == htsc_pkg::CLAMP_LOW))
    else $error("reserved humidity clamp code on output");

  a_clamp_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.rh_clamp == htsc_pkg::CLAMP_HIGH)
      |-> out_word.rh_centi == htsc_pkg::RH_MAX_CENTI)
    else $error("high clamp without 100 percent");

  a_rh_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.rh_clamp == htsc_pkg::CLAMP_NONE)
      |-> (out_word.rh_centi >= htsc_pkg::RH_MIN_CENTI &&
           out_word.rh_centi <= htsc_pkg::RH_MAX_CENTI))
    else $error("unclamped humidity out of range");

  a_first_open: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[1] |-> !in_stall)
    else $error("input stalled while first stage is empty");
`endif

endmodule

/* hw/rtl/htsc_rnd_mul.sv */
// Two-stage split magnitude multiplier with round-half-up back to FRAC_BITS.
module htsc_rnd_mul #(
  parameter int FRAC_BITS = htsc_pkg::DEF_FRAC_BITS,
  parameter int A_W       = htsc_pkg::DEF_FRAC_BITS + 10,
  parameter int B_W       = htsc_pkg::DEF_FRAC_BITS + 3
) (
  input  logic                         clk,
  input  htsc_pkg::mul_en_t            en,
  input  logic [A_W-1:0]               a_mag,
  input  logic [B_W-1:0]               b_mag,
  output logic [A_W+B_W-FRAC_BITS-1:0] prod
);

  localparam int SA = (A_W + 1) / 2;
  localparam int SB = (B_W + 1) / 2;
  localparam int HA = A_W - SA;
  localparam int HB = B_W - SB;
  localparam int PW = A_W + B_W;
  localparam int MW = PW - FRAC_BITS;
  localparam longint HALF = longint'(1) <<< (FRAC_BITS - 1);

  logic [SA+SB-1:0] pll_r;
  logic [SA+HB-1:0] plh_r;
  logic [HA+SB-1:0] phl_r;
  logic [HA+HB-1:0] phh_r;
  logic [PW-1:0]    sum;
  logic [MW-1:0]    prod_nxt;
  logic [MW-1:0]    prod_r;

  // Partial products
  always_ff @(posedge clk) begin
    if (en.s4) begin
      pll_r <= (SA+SB)'(a_mag[SA-1:0]) * (SA+SB)'(b_mag[SB-1:0]);
      plh_r <= (SA+HB)'(a_mag[SA-1:0]) * (SA+HB)'(b_mag[B_W-1:SB]);
      phl_r <= (HA+SB)'(a_mag[A_W-1:SA]) * (HA+SB)'(b_mag[SB-1:0]);
      phh_r <= (HA+HB)'(a_mag[A_W-1:SA]) * (HA+HB)'(b_mag[B_W-1:SB]);
    end
  end

  always_comb begin
    sum = (PW'(phh_r) << (SA + SB)) + (PW'(phl_r) << SA) + (PW'(plh_r) << SB)
        + PW'(pll_r) + PW'(HALF);
    prod_nxt = sum[PW-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule
